// ----- sv/rau_pkg.sv -----
package rau_pkg;

   localparam int OperandWidth = 32;
   localparam int ResWidth     = 64;

   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_CMP = 3'd4;
   localparam logic [2:0] FUNC_RED = 3'd5;

   localparam logic [1:0] ORDER_LT = 2'b11;
   localparam logic [1:0] ORDER_EQ = 2'b00;
   localparam logic [1:0] ORDER_GT = 2'b01;

   typedef struct packed {
      logic start;
      logic [ResWidth-1:0] num;
      logic [ResWidth-1:0] den;
   } red_req_type;

   typedef struct packed {
      logic done;
      logic [ResWidth-1:0] num;
      logic [ResWidth-1:0] den;
   } red_rsp_type;

endpackage

// ----- sv/rational_arithmetic_unit_top.sv -----
// channel | dir | tdata fields (low bit first)                  | tuser
// req     | in  | a_num[31:0] a_den b_num b_den (128 bits)      | func[2:0]
// rsp     | out | res_num[63:0] res_den[126:64] order[128:127]  | status
// After a beat is accepted, a and b are each reduced by Euclid's algorithm, then
// multiplied, combined and the result reduced for add, sub, mul and div; compare
// skips the result reduction, reduce returns reduced a, and an invalid beat goes
// straight to the result. One item at a time.
// Reset clears control only. A stalled result holds the block; req_tready is low
// until rsp is taken.
module rational_arithmetic_unit_top
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidth
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_num, a_den, b_num, b_den
   input  logic [2:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // res_num, res_den, order, zero pad
   output logic         rsp_tuser    // status
);

   localparam int W = ResWidth;
   localparam int OW = OPERAND_WIDTH;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RA   = 4'd1;
   localparam logic [3:0] S_RAW  = 4'd2;
   localparam logic [3:0] S_RB   = 4'd3;
   localparam logic [3:0] S_RBW  = 4'd4;
   localparam logic [3:0] S_M1   = 4'd5;
   localparam logic [3:0] S_M2   = 4'd6;
   localparam logic [3:0] S_M3   = 4'd7;
   localparam logic [3:0] S_COMB = 4'd8;
   localparam logic [3:0] S_RR   = 4'd9;
   localparam logic [3:0] S_RRW  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [2:0] func_ff, func_in;
   logic       an_ff, an_in, bn_ff, bn_in, rn_ff, rn_in;
   logic [W-1:0] an_m_ff, an_m_in, ad_m_ff, ad_m_in, bn_m_ff, bn_m_in, bd_m_ff, bd_m_in;
   logic [W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [W-1:0] rnum_ff, rnum_in, rden_ff, rden_in;
   logic [1:0]  ord_ff, ord_in;
   logic        st_ff, st_in;

   // operand decode
   function automatic logic [OW-1:0] fld(input logic [31:0] v);
      fld = v[OW-1:0];
   endfunction
   logic [OW-1:0] ra_n, ra_d, rb_n, rb_d;
   assign ra_n = fld(req_tdata[31:0]);
   assign ra_d = fld(req_tdata[63:32]);
   assign rb_n = fld(req_tdata[95:64]);
   assign rb_d = fld(req_tdata[127:96]);

   function automatic logic [W-1:0] mag(input logic [OW-1:0] v);
      logic [OW-1:0] n;
      n = v[OW-1] ? (~v + 1'b1) : v;
      mag = W'(n);
   endfunction

   red_req_type rreq;
   red_rsp_type rrsp;
   rau_reduce u_reduce (.clock, .reset, .req(rreq), .rsp(rrsp));

   logic [OperandWidth-1:0] mul_a, mul_b;
   logic [W-1:0] prod;
   rau_mul u_mul (.clock, .op_a(mul_a), .op_b(mul_b), .prod);

   always_comb begin
      unique case (state_ff)
         S_M1: begin
            mul_a = OperandWidth'(an_m_ff);
            mul_b = (func_ff == FUNC_MUL) ? OperandWidth'(bn_m_ff) : OperandWidth'(bd_m_ff);
         end
         S_M2: begin
            mul_a = (func_ff == FUNC_DIV) ? OperandWidth'(ad_m_ff) : OperandWidth'(bn_m_ff);
            mul_b = (func_ff == FUNC_DIV) ? OperandWidth'(bn_m_ff) : OperandWidth'(ad_m_ff);
         end
         default: begin
            mul_a = OperandWidth'(ad_m_ff);
            mul_b = OperandWidth'(bd_m_ff);
         end
      endcase
   end

   logic t2n;
   logic [W-1:0] sum_big, sum_small;
   logic         sub_path;
   always_comb begin
      t2n = (func_ff == FUNC_SUB) ? !bn_ff : bn_ff;
      sub_path = (an_ff != t2n);
      sum_big = (p1_ff >= p2_ff) ? p1_ff : p2_ff;
      sum_small = (p1_ff >= p2_ff) ? p2_ff : p1_ff;
   end

   logic bad;
   assign bad = (req_tuser > FUNC_RED) || (ra_d == '0) ||
                (req_tuser != FUNC_RED && rb_d == '0) ||
                (req_tuser == FUNC_DIV && rb_n == '0);

   always_comb begin
      state_in = state_ff; func_in = func_ff;
      an_in = an_ff; bn_in = bn_ff; rn_in = rn_ff;
      an_m_in = an_m_ff; ad_m_in = ad_m_ff; bn_m_in = bn_m_ff; bd_m_in = bd_m_ff;
      p1_in = p1_ff; p2_in = p2_ff;
      rnum_in = rnum_ff; rden_in = rden_ff; ord_in = ord_ff; st_in = st_ff;
      rreq.start = 1'b0; rreq.num = an_m_ff; rreq.den = ad_m_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               an_m_in = mag(ra_n); ad_m_in = mag(ra_d);
               bn_m_in = mag(rb_n); bd_m_in = mag(rb_d);
               an_in = (ra_n[OW-1] != ra_d[OW-1]) && ra_n != '0;
               bn_in = (rb_n[OW-1] != rb_d[OW-1]) && rb_n != '0;
               ord_in = ORDER_EQ; rnum_in = '0; rden_in = '0; rn_in = 1'b0;
               st_in = bad;
               state_in = bad ? S_OUT : S_RA;
            end
         end
         S_RA: begin
            rreq.start = 1'b1; state_in = S_RAW;
         end
         S_RAW: if (rrsp.done) begin
            an_m_in = rrsp.num; ad_m_in = rrsp.num == '0 ? W'(1) : rrsp.den;
            if (func_ff == FUNC_RED) begin
               rn_in = an_ff; rnum_in = an_in ? (~rrsp.num + 1'b1) : rrsp.num;
               rden_in = ad_m_in; state_in = S_OUT;
            end else state_in = S_RB;
         end
         S_RB: begin
            rreq.start = 1'b1; rreq.num = bn_m_ff; rreq.den = bd_m_ff;
            state_in = S_RBW;
         end
         S_RBW: if (rrsp.done) begin
            bn_m_in = rrsp.num; bd_m_in = rrsp.num == '0 ? W'(1) : rrsp.den;
            state_in = S_M1;
         end
         S_M1: state_in = S_M2;
         S_M2: begin p1_in = prod; state_in = S_M3; end
         S_M3: begin p2_in = prod; state_in = S_COMB; end
         S_COMB: begin
            unique case (func_ff)
               FUNC_CMP: begin
                  if (an_ff != bn_ff) ord_in = an_ff ? ORDER_LT : ORDER_GT;
                  else if (p1_ff == p2_ff) ord_in = ORDER_EQ;
                  else ord_in = ((p1_ff > p2_ff) != an_ff) ? ORDER_GT : ORDER_LT;
                  state_in = S_OUT;
               end
               FUNC_ADD, FUNC_SUB: begin
                  p1_in = sub_path ? (sum_big - sum_small) : (p1_ff + p2_ff);
                  rn_in = sub_path ? ((p1_ff >= p2_ff) ? an_ff : t2n) : an_ff;
                  p2_in = prod;
                  state_in = S_RR;
               end
               FUNC_MUL: begin
                  rn_in = an_ff != bn_ff; p2_in = prod; state_in = S_RR;
               end
               default: begin
                  rn_in = an_ff != bn_ff; state_in = S_RR;
               end
            endcase
         end
         S_RR: begin
            rreq.start = 1'b1; rreq.num = p1_ff; rreq.den = p2_ff;
            state_in = S_RRW;
         end
         S_RRW: if (rrsp.done) begin
            rn_in = rn_ff && rrsp.num != '0;
            rnum_in = rn_in ? (~rrsp.num + 1'b1) : rrsp.num;
            rden_in = rrsp.num == '0 ? W'(1) : rrsp.den;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff <= func_in; an_ff <= an_in; bn_ff <= bn_in; rn_ff <= rn_in;
      an_m_ff <= an_m_in; ad_m_ff <= ad_m_in; bn_m_ff <= bn_m_in; bd_m_ff <= bd_m_in;
      p1_ff <= p1_in; p2_ff <= p2_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; ord_ff <= ord_in; st_ff <= st_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {7'd0, ord_ff, rden_ff[62:0], rnum_ff};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while holding result");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rnum_ff == '0 && rden_ff == '0 && ord_ff == ORDER_EQ))
      else $error("invalid result not zero");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser && func_ff != FUNC_CMP) |-> rden_ff != '0)
      else $error("zero denominator on valid result");

endmodule

// ----- sv/rau_reduce.sv -----
// Reduces num/den by their gcd: binary-long-division remainder loop for the gcd,
// then two bit-serial quotients. One shared subtract/compare unit.
module rau_reduce
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  red_req_type req,
   output red_rsp_type rsp
);

   localparam int W  = ResWidth;
   localparam int CW = $clog2(W + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GCD   = 3'd1;
   localparam logic [2:0] S_QNUM  = 3'd2;
   localparam logic [2:0] S_QDEN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [W-1:0] y_ff, y_in;
   logic [W-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [W-1:0] num_ff, num_in, den_ff, den_in, g_ff, g_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // shared unit: shift remainder left, bring in a bit, trial subtract divisor
   logic [W-1:0] divisor, dividend;
   logic [W:0]   shifted, diff;
   logic         fits;

   always_comb begin
      unique case (state_ff)
         S_GCD:   begin divisor = y_ff; dividend = quo_ff; end
         default: begin divisor = g_ff; dividend = quo_ff; end
      endcase
      shifted = {rem_ff, dividend[W-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = !diff[W];
   end

   always_comb begin
      state_in = state_ff;
      y_in = y_ff; rem_in = rem_ff; quo_in = quo_ff;
      num_in = num_ff; den_in = den_ff; g_in = g_ff; cnt_in = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               num_in = req.num;
               den_in = req.den;
               if (req.den == '0 || req.num == '0) begin
                  g_in = (req.num == '0) ? req.den : req.num;
               end
               y_in   = req.den;
               rem_in = '0;
               quo_in = req.num;
               cnt_in = CW'(W);
               state_in = (req.den == '0) ? S_DONE : S_GCD;
               if (req.den == '0) g_in = '0;
            end
         end
         S_GCD: begin
            // x mod y, one bit a cycle
            rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               y_in = rem_in;
               if (rem_in == '0) begin
                  g_in   = y_ff;
                  rem_in = '0;
                  quo_in = num_ff;
                  cnt_in = CW'(W);
                  state_in = S_QNUM;
               end else begin
                  quo_in = y_ff;
                  rem_in = '0;
                  cnt_in = CW'(W);
               end
            end
         end
         S_QNUM, S_QDEN: begin
            rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               rem_in = '0;
               cnt_in = CW'(W);
               if (state_ff == S_QNUM) begin
                  num_in = quo_in;
                  quo_in = den_ff;
                  state_in = S_QDEN;
               end else begin
                  den_in = quo_in;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      y_ff <= y_in; rem_ff <= rem_in; quo_ff <= quo_in;
      num_ff <= num_in; den_ff <= den_in; g_ff <= g_in; cnt_ff <= cnt_in;
   end

   assign rsp.done = (state_ff == S_DONE);
   assign rsp.num  = num_ff;
   assign rsp.den  = den_ff;

   a_done_one: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("done held");
   a_gcd_nz: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QNUM) |-> (g_ff != '0)) else $error("zero gcd in divide");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (req.start && state_ff == S_GCD) |-> 1'b0) else $error("start while busy");

endmodule

// ----- sv/rau_mul.sv -----
// 32x32 unsigned multiply, one product a cycle, registered.
module rau_mul
   import rau_pkg::*;
(
   input  logic                  clock,
   input  logic [OperandWidth-1:0] op_a,
   input  logic [OperandWidth-1:0] op_b,
   output logic [ResWidth-1:0]   prod
);

   logic [ResWidth-1:0] prod_ff, prod_in;

   assign prod_in = ResWidth'(op_a) * ResWidth'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
